>>> sv/sdn_pkg.sv
`default_nettype none

package sdn_pkg;

  // Width of one stored term.
  localparam int unsigned TermW = 64;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_READ,
    OP_CHK,
    OP_APP,
    OP_RINC,
    OP_MIN,
    OP_OFS,
    OP_SUB,
    OP_GCD_LOAD,
    OP_GCD_STEP,
    OP_GFIN,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_WR
  } dp_op_t;

  // A separate emit code would not fit the four-bit field, so emit has a flag.
  typedef struct packed {
    dp_op_t op;
    logic   emit;
    logic   clr_idx;
    logic   inc_idx;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic chk_ok;
    logic nz_pred;
    logic rounds_lt;
    logic sub_needed;
    logic term_nz;
    logic gcd_done;
    logic gcd_one;
    logic div_done;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_RND_CHK,
    ST_RD_CHK,
    ST_EX_CHK,
    ST_CHK_DEC,
    ST_RD_APP,
    ST_EX_APP,
    ST_APP_DONE,
    ST_RD_MIN,
    ST_EX_MIN,
    ST_OFS,
    ST_RD_SUB,
    ST_EX_SUB,
    ST_RD_GCD,
    ST_EX_GCD,
    ST_GCD_RUN,
    ST_GFIN,
    ST_RD_DIV,
    ST_EX_DIV,
    ST_DIV_RUN,
    ST_DIV_WR,
    ST_RD_OUT,
    ST_EX_OUT
  } state_t;

endpackage

`default_nettype wire

>>> sv/sdn_ctrl.sv
`default_nettype none

module sdn_ctrl
  import sdn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    last,
  input  wire status_t status,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.emit    = 1'b0;
    cmd.clr_idx = 1'b0;
    cmd.inc_idx = 1'b0;
    busy        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // No word is taken while reset is held.
        busy = rst;
        if (start && !rst) begin
          cmd.op = OP_LOAD;
          if (last) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.op     = OP_INIT;
        state_next = ST_RND_CHK;
      end
      ST_RND_CHK: begin
        cmd.clr_idx = 1'b1;
        state_next  = status.rounds_lt ? ST_RD_CHK : ST_RD_MIN;
      end
      ST_RD_CHK: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_CHK;
      end
      ST_EX_CHK: begin
        cmd.op = OP_CHK;
        if (status.last_idx) begin
          state_next = ST_CHK_DEC;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_CHK;
        end
      end
      ST_CHK_DEC: begin
        cmd.clr_idx = 1'b1;
        state_next  = (status.chk_ok && status.nz_pred) ? ST_RD_APP : ST_RD_MIN;
      end
      ST_RD_APP: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_APP;
      end
      ST_EX_APP: begin
        cmd.op = OP_APP;
        if (status.last_idx) begin
          state_next = ST_APP_DONE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_APP;
        end
      end
      ST_APP_DONE: begin
        cmd.op     = OP_RINC;
        state_next = ST_RND_CHK;
      end
      ST_RD_MIN: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_MIN;
      end
      ST_EX_MIN: begin
        cmd.op = OP_MIN;
        if (status.last_idx) begin
          state_next = ST_OFS;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_MIN;
        end
      end
      ST_OFS: begin
        cmd.op      = OP_OFS;
        cmd.clr_idx = 1'b1;
        state_next  = status.sub_needed ? ST_RD_SUB : ST_RD_GCD;
      end
      ST_RD_SUB: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_SUB;
      end
      ST_EX_SUB: begin
        cmd.op = OP_SUB;
        if (status.last_idx) begin
          cmd.clr_idx = 1'b1;
          state_next  = ST_RD_GCD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_SUB;
        end
      end
      ST_RD_GCD: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_GCD;
      end
      ST_EX_GCD: begin
        cmd.op = OP_GCD_LOAD;
        if (status.term_nz) begin
          state_next = ST_GCD_RUN;
        end else if (status.last_idx) begin
          state_next = ST_GFIN;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_GCD;
        end
      end
      ST_GCD_RUN: begin
        cmd.op = OP_GCD_STEP;
        if (status.gcd_done) begin
          if (status.last_idx) begin
            state_next = ST_GFIN;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = ST_RD_GCD;
          end
        end
      end
      ST_GFIN: begin
        cmd.op      = OP_GFIN;
        cmd.clr_idx = 1'b1;
        state_next  = status.gcd_one ? ST_RD_OUT : ST_RD_DIV;
      end
      ST_RD_DIV: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_DIV;
      end
      ST_EX_DIV: begin
        cmd.op     = OP_DIV_LOAD;
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_done) begin
          state_next = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        cmd.op = OP_DIV_WR;
        if (status.last_idx) begin
          cmd.clr_idx = 1'b1;
          state_next  = ST_RD_OUT;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_DIV;
        end
      end
      ST_RD_OUT: begin
        cmd.op     = OP_READ;
        state_next = ST_EX_OUT;
      end
      ST_EX_OUT: begin
        cmd.emit = 1'b1;
        if (status.last_idx) begin
          state_next = ST_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_RD_OUT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sdn_datapath.sv
`default_nettype none

module sdn_datapath
  import sdn_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
)
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cmd_t         cmd,
  input  wire logic [3:0]   max_rounds,
  input  wire logic [62:0]  value,
  output status_t           status,
  output logic              done,
  output logic [63:0]       term,
  output logic [3:0]        rounds_done,
  output logic [61:0]       offset,
  output logic [62:0]       factor,
  output logic              final_term
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [TermW-1:0] mem [MAX_LEN];
  logic             we;
  logic [IW-1:0]    waddr;
  logic [TermW-1:0] wdata;
  logic [TermW-1:0] rdata;

  logic [LW-1:0]    len;
  logic [IW-1:0]    idx;
  logic [TermW-1:0] prev;
  logic             chk_ok;
  logic             nz_pred;
  logic [3:0]       rcnt;
  logic [TermW-1:0] min_val;
  logic             min_found;
  logic [62:0]      offset_reg;
  logic [TermW-1:0] g_acc;
  logic [TermW-1:0] gcd_reg;
  logic [TermW-1:0] ga;
  logic [TermW-1:0] gb;
  logic [5:0]       gk;
  logic [TermW-1:0] dq;
  logic [TermW-1:0] dr;
  logic [6:0]       dcnt;
  logic             dneg;

  logic [TermW-1:0] rmag;
  logic [TermW-1:0] g_final;
  logic             g_end;
  logic [TermW:0]   dtrial;
  logic             dfit;

  assign rmag    = rdata[TermW-1] ? (TermW'(0) - rdata) : rdata;
  assign g_final = (g_acc == '0) ? TermW'(1) : g_acc;
  assign g_end   = (ga == '0) || (gb == '0);
  assign dtrial  = {dr, dq[TermW-1]};
  assign dfit    = dtrial >= {1'b0, gcd_reg};

  // Status back to the controller.
  assign status.last_idx   = (LW'(idx) + LW'(1)) == len;
  assign status.chk_ok     = chk_ok;
  assign status.nz_pred    = nz_pred;
  assign status.rounds_lt  = rcnt < max_rounds;
  assign status.sub_needed = min_found && (min_val != '0);
  assign status.term_nz    = rdata != '0;
  assign status.gcd_done   = g_end;
  assign status.gcd_one    = g_final == TermW'(1);
  assign status.div_done   = dcnt == 7'd64;

  // Term store write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    unique case (cmd.op)
      OP_LOAD: begin
        we    = len != LW'(MAX_LEN);
        waddr = len[IW-1:0];
        wdata = {value[62], value};
      end
      OP_APP: begin
        we    = 1'b1;
        wdata = rdata - prev;
      end
      OP_SUB: begin
        we    = 1'b1;
        wdata = rdata - min_val;
      end
      OP_DIV_WR: begin
        we    = 1'b1;
        wdata = dneg ? (TermW'(0) - dq) : dq;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Term store with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.op == OP_READ) begin
      rdata <= mem[idx];
    end
  end

  // Length and element index.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      idx <= '0;
    end else begin
      if (cmd.op == OP_LOAD && len != LW'(MAX_LEN)) begin
        len <= len + LW'(1);
      end else if (cmd.emit && status.last_idx) begin
        len <= '0;
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // Per-pass scan state: predecessor, round checks and minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      chk_ok    <= 1'b1;
      nz_pred   <= 1'b0;
      min_found <= 1'b0;
      min_val   <= '0;
    end else if (cmd.clr_idx) begin
      prev      <= '0;
      chk_ok    <= 1'b1;
      nz_pred   <= 1'b0;
      min_found <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CHK: begin
          if ($signed(rdata) < $signed(prev)) begin
            chk_ok <= 1'b0;
          end
          if (prev != '0) begin
            nz_pred <= 1'b1;
          end
          prev <= rdata;
        end
        OP_APP: begin
          prev <= rdata;
        end
        OP_MIN: begin
          if (!rdata[TermW-1] && (!min_found || rdata < min_val)) begin
            min_val   <= rdata;
            min_found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Run results: round count, offset and factor.
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt       <= '0;
      offset_reg <= '0;
      gcd_reg    <= TermW'(1);
    end else begin
      unique case (cmd.op)
        OP_INIT: rcnt <= '0;
        OP_RINC: rcnt <= rcnt + 4'd1;
        OP_OFS:  offset_reg <= status.sub_needed ? min_val[62:0] : 63'd0;
        OP_GFIN: gcd_reg <= g_final;
        default: begin
        end
      endcase
    end
  end

  // Binary gcd unit, one step per cycle.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INIT: begin
        g_acc <= '0;
      end
      OP_GCD_LOAD: begin
        ga <= g_acc;
        gb <= rmag;
        gk <= '0;
      end
      OP_GCD_STEP: begin
        if (g_end) begin
          g_acc <= (ga | gb) << gk;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + 6'd1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
      default: begin
      end
    endcase
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_DIV_LOAD: begin
        dq   <= rmag;
        dr   <= '0;
        dcnt <= '0;
        dneg <= rdata[TermW-1];
      end
      OP_DIV_STEP: begin
        if (dcnt != 7'd64) begin
          dr   <= dfit ? TermW'(dtrial - {1'b0, gcd_reg}) : dtrial[TermW-1:0];
          dq   <= {dq[TermW-2:0], dfit};
          dcnt <= dcnt + 7'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      term       <= rdata;
      final_term <= status.last_idx;
    end
  end

  assign rounds_done = rcnt;
  assign offset      = offset_reg[61:0];
  assign factor      = gcd_reg[62:0];

endmodule

`default_nettype wire

>>> sv/sequence_delta_normalizer_core.sv
// Sequence delta normalizer.
// Words come in on the command port: a word is taken at a clock edge with
// start high and busy low. Each word carries one term (value) and a last flag.
// Terms are stored one per cycle; terms beyond MAX_LEN are dropped.
// On the word marked last the block raises busy and reduces the stored
// sequence: difference rounds (each a check pass and, if that allows it,
// an apply pass), a minimum pass, an optional subtract pass, a gcd pass
// over the nonzero terms (binary gcd) and an optional divide pass with a
// one-bit-per-cycle divider. Then one result word per stored term leaves,
// each marked by done for one cycle, final_term set on the last one.
// The receiver cannot stall; results are taken as they appear.
// busy falls in the cycle that carries the last result word.
// max_rounds is written through the APB port at address 0; the user must
// do so only while idle, since the block itself does not enforce it.
// Reset (synchronous, rst high) empties the store and sets max_rounds to 1;
// busy stays high while reset is held.
`default_nettype none

module sequence_delta_normalizer_core
  import sdn_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [62:0] value,
  input  wire logic        last,
  output logic             done,
  output logic [63:0]      term,
  output logic [3:0]       rounds_done,
  output logic [61:0]      offset,
  output logic [62:0]      factor,
  output logic             final_term,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] max_rounds;
  cmd_t       cmd;
  status_t    status;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rounds <= 4'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_rounds <= pwdata[3:0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {28'd0, max_rounds};

  sdn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  sdn_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .max_rounds  (max_rounds),
    .value       (value),
    .status      (status),
    .done        (done),
    .term        (term),
    .rounds_done (rounds_done),
    .offset      (offset),
    .factor      (factor),
    .final_term  (final_term)
  );

endmodule

`default_nettype wire

>>> tb/sequence_delta_normalizer_core_tb.sv
`timescale 1ns / 100ps

module sequence_delta_normalizer_core_tb;
  import sdn_pkg::*;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned RandomWords = 420;
  localparam logic [2:0] AddrMaxRounds = 3'd0;

  // One reduced term as it should leave the block.
  typedef struct {
    logic [63:0] term;
    logic [3:0]  rounds;
    logic [61:0] offset;
    logic [62:0] factor;
    logic        fin;
  } reduced_t;

  // Directed row: one word, with a typed result for single-term runs.
  typedef struct {
    logic [62:0] value;
    logic        last;
    logic        typed;
    logic [63:0] term;
    logic [3:0]  rounds;
    logic [61:0] offset;
    logic [62:0] factor;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [62:0] value;
  logic        last;
  logic        done;
  logic [63:0] term;
  logic [3:0]  rounds_done;
  logic [61:0] offset;
  logic [62:0] factor;
  logic        final_term;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sequence_delta_normalizer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .last(last),
    .done(done), .term(term), .rounds_done(rounds_done), .offset(offset),
    .factor(factor), .final_term(final_term), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: stored terms, their count and the round limit.
  logic [63:0] seq_store [StoreDepth];
  int unsigned seq_len;
  logic [3:0]  round_limit;
  reduced_t    pending_terms[$];

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned runs_done;
  int unsigned terms_seen;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // One difference round; the store changes only if the round is allowed.
  function automatic bit delta_round();
    logic [63:0] nxt [StoreDepth];
    logic [63:0] prev;
    bit          any_pred;
    any_pred = 1'b0;
    for (int j = 0; j < seq_len; j++) begin
      prev = (j == 0) ? 64'd0 : seq_store[j - 1];
      if ($signed(seq_store[j]) < $signed(prev)) return 1'b0;
      nxt[j] = seq_store[j] - prev;
      if (prev != 0) any_pred = 1'b1;
    end
    if (!any_pred) return 1'b0;
    for (int j = 0; j < seq_len; j++) seq_store[j] = nxt[j];
    return 1'b1;
  endfunction

  // Reduce the stored sequence and queue one expected word per term.
  task automatic reduce_and_queue();
    logic [3:0]  r;
    logic [63:0] mn;
    logic [63:0] g;
    logic [63:0] ofs;
    bit          found;
    reduced_t    w;
    r = 0;
    while (r < round_limit && delta_round()) r++;
    found = 1'b0;
    mn = 0;
    for (int i = 0; i < seq_len; i++)
      if (!seq_store[i][63] && (!found || seq_store[i] < mn)) begin
        mn = seq_store[i];
        found = 1'b1;
      end
    ofs = 0;
    if (found && mn != 0) begin
      for (int i = 0; i < seq_len; i++) seq_store[i] -= mn;
      ofs = mn;
    end
    g = 0;
    for (int i = 0; i < seq_len; i++)
      if (seq_store[i] != 0)
        g = gcd64(g, seq_store[i][63] ? -seq_store[i] : seq_store[i]);
    if (g == 0) g = 1;
    if (g != 1)
      for (int i = 0; i < seq_len; i++)
        seq_store[i] = seq_store[i][63] ? -((-seq_store[i]) / g) : seq_store[i] / g;
    for (int i = 0; i < seq_len; i++) begin
      w.term = seq_store[i];
      w.rounds = r;
      w.offset = ofs[61:0];
      w.factor = g[62:0];
      w.fin = (i + 1 == seq_len);
      pending_terms = {pending_terms, w};
    end
    runs_done++;
    seq_len = 0;
  endtask

  // Accepted word: store it, and reduce on the last flag.
  task automatic absorb_word(input logic [62:0] v, input logic l);
    if (seq_len < StoreDepth) begin
      seq_store[seq_len] = {v[62], v};
      seq_len++;
    end
    if (l) reduce_and_queue();
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [62:0] v, input logic l, input bit typed = 0,
                           input reduced_t want = '{default: '0});
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? 1 : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (typed) begin
      seq_len = 0;
      runs_done++;
      pending_terms = {pending_terms, want};
    end else begin
      absorb_word(v, l);
    end
  endtask

  // Stop sending and wait until every expected word has come.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_terms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the round limit and read it back.
  task automatic set_round_limit(input logic [3:0] lim);
    logic [31:0] rd;
    apb_access(1'b1, AddrMaxRounds, {28'd0, lim}, rd);
    round_limit = lim;
    apb_access(1'b0, AddrMaxRounds, 32'd0, rd);
    if (rd[3:0] !== lim) report_mismatch("max_rounds readback", 64'(rd), 64'(lim));
  endtask

  function automatic logic [62:0] wide_random();
    return 63'({$urandom, $urandom});
  endfunction

  // One random sequence, mostly nondecreasing polynomials so rounds apply.
  task automatic random_sequence(output int unsigned sent);
    logic [62:0] seqv [48];
    int unsigned n;
    int unsigned kind;
    longint      c0, c1, c2, c3, sc, k;
    kind = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
    if (kind >= 93 && kind < 97) n = $urandom_range(33, 40);
    c0 = longint'($urandom_range(20)) - (($urandom_range(3) == 0) ? 10 : 0);
    c1 = $urandom_range(20);
    c2 = $urandom_range(3) == 0 ? 0 : $urandom_range(20);
    c3 = $urandom_range(2) == 0 ? 0 : $urandom_range(20);
    sc = longint'(1) << $urandom_range(38);
    if ($urandom_range(1)) sc = sc * $urandom_range(1, 9);
    for (int i = 0; i < n; i++) begin
      k = i;
      if (kind < 55 || (kind >= 93 && kind < 97))
        seqv[i] = 63'(sc * (c0 + c1 * k + c2 * k * k + c3 * k * k * k));
      else if (kind < 65)
        seqv[i] = (c1 < 5) ? 63'd0 : 63'(sc * c0);
      else if (kind < 80)
        seqv[i] = 63'(sc * (longint'($urandom_range(100)) - 50));
      else
        seqv[i] = wide_random();
    end
    for (int i = 0; i < n; i++) send_word(seqv[i], i == n - 1);
    sent = n;
  endtask

  // Every word leaving the block must match the oldest expectation.
  always @(posedge clk) begin
    reduced_t w;
    if (!rst && done) begin
      terms_seen++;
      if (pending_terms.size() == 0) begin
        report_mismatch("unexpected term", term, 64'd0);
      end else begin
        w = pending_terms.pop_front();
        if (term !== w.term) report_mismatch("term", term, w.term);
        if (rounds_done !== w.rounds)
          report_mismatch("rounds_done", 64'(rounds_done), 64'(w.rounds));
        if (offset !== w.offset) report_mismatch("offset", 64'(offset), 64'(w.offset));
        if (factor !== w.factor) report_mismatch("factor", 64'(factor), 64'(w.factor));
        if (final_term !== w.fin)
          report_mismatch("final_term", 64'(final_term), 64'(w.fin));
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("timeout: no word moved in %0d cycles", WatchLimit);
      $display("sequence_delta_normalizer_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t        rows [$];
    reduced_t    want;
    logic [3:0]  limits [6];
    int unsigned n;
    int unsigned target;
    start = 1'b0;
    value = '0;
    last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    seq_len = 0;
    round_limit = 4'd1;
    mismatches = 0;
    words_sent = 0;
    runs_done = 0;
    terms_seen = 0;
    quiet_cycles = 0;
    idle_pct = 14;
    limits = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd7, 4'd2};

    // Directed rows: single-term extremes with typed results, then short runs.
    rows = '{
      '{63'd0, 1'b1, 1'b1, 64'd0, 4'd0, 62'd0, 63'd1},
      '{63'h3FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'd0, 4'd0, 62'h3FFF_FFFF_FFFF_FFFF, 63'd1},
      '{63'h4000_0000_0000_0000, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 62'd0,
        63'h4000_0000_0000_0000},
      '{63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 62'd0, 63'd1},
      '{63'd1, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd4, 1'b0, 1'b0, 0, 0, 0, 0},
      '{63'd9, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd16, 1'b1, 1'b0, 0, 0, 0, 0},
      '{-63'sd6, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd3, 1'b0, 1'b0, 0, 0, 0, 0},
      '{63'd9, 1'b1, 1'b0, 0, 0, 0, 0},
      '{63'd0, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd0, 1'b1, 1'b0, 0, 0, 0, 0},
      '{63'd5, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd2, 1'b1, 1'b0, 0, 0, 0, 0},
      '{63'd7, 1'b0, 1'b0, 0, 0, 0, 0}, '{63'd7, 1'b0, 1'b0, 0, 0, 0, 0},
      '{63'd7, 1'b1, 1'b0, 0, 0, 0, 0},
      '{-63'sd4, 1'b0, 1'b0, 0, 0, 0, 0}, '{-63'sd8, 1'b0, 1'b0, 0, 0, 0, 0},
      '{63'd12, 1'b1, 1'b0, 0, 0, 0, 0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      want.term = rows[i].term;
      want.rounds = rows[i].rounds;
      want.offset = rows[i].offset;
      want.factor = rows[i].factor;
      want.fin = 1'b1;
      send_word(rows[i].value, rows[i].last, rows[i].typed, want);
    end

    // Random phases, each under its own round limit; one phase never idles.
    foreach (limits[p]) begin
      drain();
      set_round_limit(limits[p]);
      idle_pct = (p == 2) ? 0 : 14;
      target = words_sent + RandomWords / 6;
      while (words_sent < target) begin
        random_sequence(n);
        if ($urandom_range(15) == 0) drain();
      end
    end
    drain();
    repeat (50) @(posedge clk);

    $display("sent %0d words in %0d runs under six round limits, checked %0d terms",
             words_sent, runs_done, terms_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("sequence_delta_normalizer_core_tb OK");
    end else begin
      $display("sequence_delta_normalizer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
